// ===== sv/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, constants and a helper function of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned STACK_DEPTH   = 16;
  localparam int unsigned FRACTION_BITS = 24;
  localparam int unsigned WORD_W        = 64;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG  = 2'd2;

  // Decimal digit runs saturate here (already above the too-large limit).
  localparam logic [32:0] DIGIT_CAP = 33'h1_FFFF_FFFF;

  localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic high;
  } alu_rsp_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== sv/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_alu
// Shared 65-bit adder used for add/subtract (one pass), shift-add multiply
// and restoring divide (one bit per cycle), with fixed-point rescaling.
// ----------------------------------------------------------------------------
module rpn_alu #(
  parameter int unsigned FRACTION_BITS = rpn_pkg::FRACTION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpn_pkg::alu_cmd_t cmd_i,
  input  logic [63:0]      opb_i,   // B, the lower operand
  input  logic [63:0]      opa_i,   // A, the top operand
  output rpn_pkg::alu_rsp_t rsp_o,
  output logic [63:0]      res_o
);

  localparam int unsigned NW = 64 + FRACTION_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic             busy_q, busy_d, conv_q, conv_d, done_q, done_d;
  logic             high_q, high_d, neg_q, neg_d, dovf_q, dovf_d;
  rpn_pkg::alu_op_e op_q, op_d;
  logic [63:0]      hi_q, hi_d, lo_q, lo_d, m_q, m_d, res_q, res_d;
  logic [NW-1:0]    n_q, n_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic [64:0] add_a, add_b;
  logic        add_sub;
  logic [65:0] sum;
  logic [63:0] cv_mag;
  logic        cv_ovf, ge;

  always_comb begin
    add_a   = {1'b0, hi_q};
    add_b   = 65'd0;
    add_sub = 1'b0;
    unique case (op_q)
      rpn_pkg::ALU_ADD: begin
        add_a = {hi_q[63], hi_q};
        add_b = {lo_q[63], lo_q};
      end
      rpn_pkg::ALU_SUB: begin
        add_a   = {hi_q[63], hi_q};
        add_b   = {lo_q[63], lo_q};
        add_sub = 1'b1;
      end
      rpn_pkg::ALU_MUL: begin
        add_a = {1'b0, hi_q};
        add_b = lo_q[0] ? {1'b0, m_q} : 65'd0;
      end
      rpn_pkg::ALU_DIV: begin
        add_a   = {hi_q, n_q[NW-1]};
        add_b   = {1'b0, m_q};
        add_sub = 1'b1;
      end
      default: ;
    endcase
    sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {65'd0, add_sub};
    ge  = sum[65];
  end

  // Rescaled magnitude of the finished product or quotient.
  always_comb begin
    if (op_q == rpn_pkg::ALU_MUL) begin
      cv_mag = {hi_q[FRACTION_BITS-1:0], lo_q[63:FRACTION_BITS]};
      cv_ovf = |hi_q[63:FRACTION_BITS];
    end else begin
      cv_mag = lo_q;
      cv_ovf = dovf_q;
    end
  end

  always_comb begin
    busy_d = busy_q;
    conv_d = conv_q;
    done_d = 1'b0;
    high_d = high_q;
    neg_d  = neg_q;
    dovf_d = dovf_q;
    op_d   = op_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    m_d    = m_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      conv_d = 1'b0;
      op_d   = cmd_i.op;
      neg_d  = opb_i[63] ^ opa_i[63];
      dovf_d = 1'b0;
      unique case (cmd_i.op)
        rpn_pkg::ALU_MUL: begin
          hi_d  = 64'd0;
          lo_d  = rpn_pkg::mag64(opa_i);
          m_d   = rpn_pkg::mag64(opb_i);
          cnt_d = CW'(64);
        end
        rpn_pkg::ALU_DIV: begin
          hi_d  = 64'd0;
          lo_d  = 64'd0;
          m_d   = rpn_pkg::mag64(opa_i);
          n_d   = {rpn_pkg::mag64(opb_i), {FRACTION_BITS{1'b0}}};
          cnt_d = CW'(NW);
        end
        default: begin
          hi_d  = opb_i;
          lo_d  = opa_i;
          cnt_d = CW'(1);
        end
      endcase
    end else if (busy_q && conv_q) begin
      busy_d = 1'b0;
      conv_d = 1'b0;
      done_d = 1'b1;
      high_d = 1'b0;
      if (neg_q) begin
        res_d = (cv_ovf || cv_mag[63]) ? rpn_pkg::WORD_MIN : (~cv_mag + 64'd1);
      end else if (cv_ovf || cv_mag[63]) begin
        res_d  = rpn_pkg::WORD_MAX;
        high_d = 1'b1;
      end else begin
        res_d = cv_mag;
      end
    end else if (busy_q) begin
      unique case (op_q)
        rpn_pkg::ALU_MUL: begin
          hi_d  = sum[64:1];
          lo_d  = {sum[0], lo_q[63:1]};
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            conv_d = 1'b1;
          end
        end
        rpn_pkg::ALU_DIV: begin
          hi_d  = ge ? sum[63:0] : add_a[63:0];
          n_d   = {n_q[NW-2:0], 1'b0};
          lo_d  = {lo_q[62:0], ge};
          // Quotient bits at weight 2^64 and above mean overflow.
          if (ge && (cnt_q > CW'(64))) begin
            dovf_d = 1'b1;
          end
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            conv_d = 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0;
          done_d = 1'b1;
          if (sum[64] != sum[63]) begin
            res_d  = sum[64] ? rpn_pkg::WORD_MIN : rpn_pkg::WORD_MAX;
            high_d = ~sum[64];
          end else begin
            res_d  = sum[63:0];
            high_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      conv_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= rpn_pkg::ALU_ADD;
    end else begin
      busy_q <= busy_d;
      conv_q <= conv_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q <= high_d;
    neg_q  <= neg_d;
    dovf_q <= dovf_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    m_q    <= m_d;
    n_q    <= n_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.high = high_q;
  assign res_o      = res_q;

endmodule

// ===== sv/rpn_stack_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Postfix expression evaluator over a Q(64-F).F fixed-point value stack.
// ----------------------------------------------------------------------------
// One character is taken per input beat. A digit is folded into the pending
// number. Any other character first pushes a pending number. An operator then
// reads its operands from the stack RAM (S_RDA, S_RDB, S_CHK), checks them in
// S_SETUP, runs in the shared ALU (one adder pass for + and -, 64 shift-add
// steps plus rescaling for *, one restoring-division bit per cycle for /) and
// writes the result back in S_FIX. Division is the slowest operator; the
// default is 24 fraction bits. The final character then reads the bottom entry
// and rounds it (S_RD0, S_RND). The block takes no beat while an item is in
// progress; a finished result waits in an output register and does not stop
// the next beat from being accepted.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core #(
  parameter int unsigned STACK_DEPTH   = rpn_pkg::STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = rpn_pkg::FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] value, [33:32] status, rest zero
);

  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);
  localparam logic [63:0] LIMIT = 64'(32'h7FFF_FFFF) << FRACTION_BITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_PUSH  = 11'b000_0000_0010,
    S_RDA   = 11'b000_0000_0100,
    S_RDB   = 11'b000_0000_1000,
    S_CHK   = 11'b000_0001_0000,
    S_SETUP = 11'b000_0010_0000,
    S_EXEC  = 11'b000_0100_0000,
    S_FIX   = 11'b000_1000_0000,
    S_RD0   = 11'b001_0000_0000,
    S_RND   = 11'b010_0000_0000,
    S_ERR   = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic              bvalid_q, bvalid_d;
  logic [32:0]       acc_q, acc_d;
  logic              innum_q, innum_d;
  logic [1:0]        err_q, err_d;
  logic              isop_q, isop_d, last_q, last_d;
  rpn_pkg::alu_op_e  op_q, op_d;
  logic [63:0]       a_q, a_d, b_q, b_d;
  logic              aav_q, aav_d, bav_q, bav_d;
  logic              ovalid_q, ovalid_d;
  logic [31:0]       oval_q, oval_d;
  logic [1:0]        ostat_q, ostat_d;

  logic              we;
  logic [63:0]       wdata;
  logic [AW-1:0]     raddr;
  logic [63:0]       rdata;
  rpn_pkg::alu_cmd_t alu_cmd;
  rpn_pkg::alu_rsp_t alu_rsp;
  logic [63:0]       alu_res;

  logic              accept, out_free, is_digit, room;
  logic [36:0]       acc_next;
  logic [63:0]       bot, bot_mag;
  logic [64:0]       rnd;
  logic [31:0]       rnd_val;

  rpn_ram #(
    .WIDTH(64),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rpn_alu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (alu_cmd),
    .opb_i (b_q),
    .opa_i (a_q),
    .rsp_o (alu_rsp),
    .res_o (alu_res)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ovalid_q || m_axis_tready_i;
  assign room            = count_q < CNTW'(STACK_DEPTH);
  assign is_digit        = (s_axis_tdata_i >= rpn_pkg::CHAR_ZERO) &&
                           (s_axis_tdata_i <= rpn_pkg::CHAR_NINE);
  assign acc_next        = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                           {29'd0, s_axis_tdata_i - rpn_pkg::CHAR_ZERO};

  // Rounding of the bottom entry, half away from zero.
  always_comb begin
    bot     = bvalid_q ? rdata : 64'd0;
    bot_mag = rpn_pkg::mag64(bot);
    rnd     = ({1'b0, bot_mag} + (65'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    if (bot[63]) begin
      rnd_val = (rnd > 65'h0_8000_0000) ? 32'h8000_0000 : (~rnd[31:0] + 32'd1);
    end else begin
      rnd_val = (rnd > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    bvalid_d = bvalid_q;
    acc_d    = acc_q;
    innum_d  = innum_q;
    err_d    = err_q;
    isop_d   = isop_q;
    last_d   = last_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    aav_d    = aav_q;
    bav_d    = bav_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    oval_d   = oval_q;
    ostat_d  = ostat_q;
    we       = 1'b0;
    wdata    = 64'(acc_q) << FRACTION_BITS;
    raddr    = '0;
    alu_cmd  = '{start: 1'b0, op: op_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = s_axis_tlast_i;
          if (err_q != rpn_pkg::STATUS_OK) begin
            if (s_axis_tlast_i) begin
              state_d = S_ERR;
            end
          end else if (is_digit) begin
            acc_d   = (acc_next > 37'(rpn_pkg::DIGIT_CAP)) ? rpn_pkg::DIGIT_CAP
                                                           : acc_next[32:0];
            innum_d = 1'b1;
            isop_d  = 1'b0;
            if (s_axis_tlast_i) begin
              state_d = S_PUSH;
            end
          end else begin
            isop_d  = 1'b1;
            state_d = S_PUSH;
            unique case (s_axis_tdata_i)
              rpn_pkg::CHAR_PLUS:  op_d = rpn_pkg::ALU_ADD;
              rpn_pkg::CHAR_MINUS: op_d = rpn_pkg::ALU_SUB;
              rpn_pkg::CHAR_STAR:  op_d = rpn_pkg::ALU_MUL;
              rpn_pkg::CHAR_SLASH: op_d = rpn_pkg::ALU_DIV;
              default:             isop_d = 1'b0;
            endcase
          end
        end
      end
      S_PUSH: begin
        if (innum_q && room) begin
          we      = 1'b1;
          count_d = count_q + CNTW'(1);
          if (count_q == '0) begin
            bvalid_d = 1'b1;
          end
        end
        acc_d   = '0;
        innum_d = 1'b0;
        if (isop_q) begin
          state_d = S_RDA;
        end else begin
          state_d = last_q ? S_RD0 : S_IDLE;
        end
      end
      S_RDA: begin
        raddr = AW'(count_q - CNTW'(1));
        aav_d = (count_q != '0);
        if (count_q != '0) begin
          count_d = count_q - CNTW'(1);
        end
        state_d = S_RDB;
      end
      S_RDB: begin
        a_d   = aav_q ? rdata : 64'd0;
        raddr = AW'(count_q - CNTW'(1));
        bav_d = (count_q != '0);
        if (count_q != '0) begin
          count_d = count_q - CNTW'(1);
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        b_d     = bav_q ? rdata : 64'd0;
        state_d = S_SETUP;
      end
      S_SETUP: begin
        if ($signed(a_q) > $signed(LIMIT) || $signed(b_q) > $signed(LIMIT)) begin
          err_d   = rpn_pkg::STATUS_TOO_BIG;
          state_d = last_q ? S_ERR : S_IDLE;
        end else if (op_q == rpn_pkg::ALU_DIV && a_q == 64'd0) begin
          err_d   = rpn_pkg::STATUS_DIV_ZERO;
          state_d = last_q ? S_ERR : S_IDLE;
        end else begin
          alu_cmd.start = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        wdata = alu_res;
        if (alu_rsp.high || $signed(alu_res) > $signed(LIMIT)) begin
          err_d   = rpn_pkg::STATUS_TOO_BIG;
          state_d = last_q ? S_ERR : S_IDLE;
        end else begin
          if (room) begin
            we      = 1'b1;
            count_d = count_q + CNTW'(1);
            if (count_q == '0) begin
              bvalid_d = 1'b1;
            end
          end
          state_d = last_q ? S_RD0 : S_IDLE;
        end
      end
      S_RD0: begin
        state_d = S_RND;
      end
      S_RND: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oval_d   = rnd_val;
          ostat_d  = rpn_pkg::STATUS_OK;
          count_d  = '0;
          bvalid_d = 1'b0;
          err_d    = rpn_pkg::STATUS_OK;
          state_d  = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oval_d   = 32'd0;
          ostat_d  = err_q;
          count_d  = '0;
          bvalid_d = 1'b0;
          acc_d    = '0;
          innum_d  = 1'b0;
          err_d    = rpn_pkg::STATUS_OK;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      bvalid_q <= 1'b0;
      acc_q    <= '0;
      innum_q  <= 1'b0;
      err_q    <= rpn_pkg::STATUS_OK;
      isop_q   <= 1'b0;
      last_q   <= 1'b0;
      op_q     <= rpn_pkg::ALU_ADD;
      aav_q    <= 1'b0;
      bav_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      bvalid_q <= bvalid_d;
      acc_q    <= acc_d;
      innum_q  <= innum_d;
      err_q    <= err_d;
      isop_q   <= isop_d;
      last_q   <= last_d;
      op_q     <= op_d;
      aav_q    <= aav_d;
      bav_q    <= bav_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    oval_q  <= oval_d;
    ostat_q <= ostat_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'd0, ostat_q, oval_q};

endmodule

// ===== sv/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[33:32] != 2'd3) &&
                        (m_axis_tdata_o[39:34] == 6'd0))
    else $error("undefined status code or padding set");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[33:32] != 2'd0) |->
      (m_axis_tdata_o[31:0] == 32'd0))
    else $error("error result carries a nonzero value");

endmodule

bind rpn_stack_evaluator_core rpn_checker u_rpn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
